// File: design/max_sum_submatrix_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the max-sum submatrix block
// Concurrent checks compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef MAX_SUM_SUBMATRIX_DEFINES_SVH
`define MAX_SUM_SUBMATRIX_DEFINES_SVH

`ifndef SYNTHESIS
`define MSM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MSM_ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define MSM_ASSERT(label, clk, rst_n, prop, msg)
`define MSM_ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif

`endif

// File: design/msm_pkg.sv
// ----------------------------------------------------------------------------
// msm_pkg
// Shared constants and types of the max-sum submatrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package msm_pkg;

  localparam int MaxRowsDef = 16;
  localparam int MaxColsDef = 16;
  localparam int ElemW      = 16;
  localparam int SumOutW    = 24;
  localparam int BoundW     = 4;
  localparam int CfgW       = 5;
  localparam int CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] RegRowCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegColCount = 2'd1;

  typedef struct packed {
    logic signed [SumOutW-1:0] sum;
    logic [BoundW-1:0]         top;
    logic [BoundW-1:0]         bottom;
    logic [BoundW-1:0]         left;
    logic [BoundW-1:0]         right;
  } msm_res_t;

endpackage

`default_nettype wire

// File: design/max_sum_submatrix.sv
// ----------------------------------------------------------------------------
// max_sum_submatrix
// Loads a signed matrix element by element, then reports the rectangle of
// largest sum with its bounds (first in (top, left, bottom, right) order).
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                   | Transaction when
//  --------+-------------------------------------------+---------------------
//  element | start_i, busy_o, element_value_i          | start_i && !busy_o
//  result  | done_o, best_sum_o, top_row_o, bottom_row_o,| done_o high (1 cycle)
//          | left_col_o, right_col_o                   |
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i           | cfg_we_i high
//
// Elements are accepted back to back while busy_o is low. The last element launches
// the search, which evaluates one rectangle per cycle through the single memory
// read port; busy_o is high from launch through the result cycle.
// Reset sets both size registers to 16 and restarts loading at element 0.
// The receiver cannot stall; the result is shown for exactly one cycle.
// A size register write abandons a partial load.
`default_nettype none

module max_sum_submatrix
  import msm_pkg::*;
#(
  parameter int MAX_ROWS = MaxRowsDef,
  parameter int MAX_COLS = MaxColsDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic signed [ElemW-1:0] element_value_i,
  output logic                         done_o,
  output logic signed [SumOutW-1:0]    best_sum_o,
  output logic [BoundW-1:0]            top_row_o,
  output logic [BoundW-1:0]            bottom_row_o,
  output logic [BoundW-1:0]            left_col_o,
  output logic [BoundW-1:0]            right_col_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [CfgW-1:0]         cfg_data_i
);

  localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [CfgW-1:0] rows_cfg_q, cols_cfg_q;
  logic [RowW-1:0] row_last, row_q;
  logic [ColW-1:0] col_last, col_q;
  logic            busy_q;
  logic            accept, load_last, search_go;
  logic            re;
  logic [AddrW-1:0] waddr, raddr;
  logic signed [ElemW-1:0] rdata;
  msm_res_t        res;

  // clamp the size registers: zero acts as one, oversize as the maximum
  always_comb begin
    if (rows_cfg_q == '0) begin
      row_last = '0;
    end else if (int'(rows_cfg_q) > MAX_ROWS) begin
      row_last = RowW'(MAX_ROWS - 1);
    end else begin
      row_last = RowW'(int'(rows_cfg_q) - 1);
    end
    if (cols_cfg_q == '0) begin
      col_last = '0;
    end else if (int'(cols_cfg_q) > MAX_COLS) begin
      col_last = ColW'(MAX_COLS - 1);
    end else begin
      col_last = ColW'(int'(cols_cfg_q) - 1);
    end
  end

  assign accept    = start_i && !busy_q;
  assign load_last = (row_q == row_last) && (col_q == col_last);
  assign search_go = accept && load_last;
  assign waddr     = AddrW'(AddrW'(row_q) * AddrW'(MAX_COLS) + AddrW'(col_q));

  // size registers; a write to either one restarts the load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= CfgW'(16);
      cols_cfg_q <= CfgW'(16);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRowCount: rows_cfg_q <= cfg_data_i;
        RegColCount: cols_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // load position and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == RegRowCount || cfg_idx_i == RegColCount)) begin
        row_q <= '0;
        col_q <= '0;
      end else if (accept) begin
        if (load_last) begin
          row_q <= '0;
          col_q <= '0;
        end else if (col_q == col_last) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      // hold busy from launch through the result cycle
      if (search_go) begin
        busy_q <= 1'b1;
      end else if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  msm_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  msm_search #(
    .MaxRows (MAX_ROWS),
    .MaxCols (MAX_COLS),
    .RowW    (RowW),
    .ColW    (ColW),
    .AddrW   (AddrW)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (search_go),
    .row_last_i (row_last),
    .col_last_i (col_last),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .done_o     (done_o),
    .res_o      (res)
  );

  assign busy_o       = busy_q;
  assign best_sum_o   = res.sum;
  assign top_row_o    = res.top;
  assign bottom_row_o = res.bottom;
  assign left_col_o   = res.left;
  assign right_col_o  = res.right;

  `include "max_sum_submatrix_defines.svh"

  `MSM_ASSERT(a_done_busy, clk_i, rst_ni, done_o |-> busy_q, "result outside a search")
  `MSM_ASSERT(a_done_frees, clk_i, rst_ni, done_o |=> !busy_q, "busy held after result")
  `MSM_ASSERT(a_go_busy, clk_i, rst_ni, search_go |=> busy_q, "search launch lost")
  `MSM_ASSERT_NEVER(a_done_twice, clk_i, rst_ni, done_o && $past(done_o), "double result")

endmodule

`default_nettype wire

// File: design/msm_store.sv
// ----------------------------------------------------------------------------
// msm_store
// Element memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module msm_store
  import msm_pkg::*;
#(
  parameter int Depth = MaxRowsDef * MaxColsDef,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [AddrW-1:0]        waddr_i,
  input  wire logic signed [ElemW-1:0] wdata_i,
  input  wire logic                    re_i,
  input  wire logic [AddrW-1:0]        raddr_i,
  output logic signed [ElemW-1:0]      rdata_o
);

  logic signed [ElemW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: design/msm_search.sv
// ----------------------------------------------------------------------------
// msm_search
// Rectangle search: walks (top, left, bottom, right) in order, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msm_search
  import msm_pkg::*;
#(
  parameter int MaxRows = MaxRowsDef,
  parameter int MaxCols = MaxColsDef,
  parameter int RowW    = (MaxRows > 1) ? $clog2(MaxRows) : 1,
  parameter int ColW    = (MaxCols > 1) ? $clog2(MaxCols) : 1,
  parameter int AddrW   = (MaxRows * MaxCols > 1) ? $clog2(MaxRows * MaxCols) : 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    go_i,
  input  wire logic [RowW-1:0]         row_last_i,
  input  wire logic [ColW-1:0]         col_last_i,
  output logic                         re_o,
  output logic [AddrW-1:0]             raddr_o,
  input  wire logic signed [ElemW-1:0] rdata_i,
  output logic                         done_o,
  output msm_res_t                     res_o
);

  localparam int ColAccW = ElemW + $clog2(MaxRows + 1) + 1;
  localparam int SumW    = ElemW + $clog2(MaxRows * MaxCols + 1) + 1;
  localparam int SatMax  = (1 << (SumOutW - 1)) - 1;
  localparam int SatMin  = -(1 << (SumOutW - 1));

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRun   = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [RowW-1:0] t_q, t_d, b_q, b_d;
  logic [ColW-1:0] l_q, l_d, r_q, r_d;
  logic issue_last;

  // stage 1 (data returns from memory)
  logic            p_first_b_q, p_first_r_q;
  logic [RowW-1:0] p_t_q, p_b_q;
  logic [ColW-1:0] p_l_q, p_r_q;
  logic            p_valid_q;

  logic signed [ColAccW-1:0] colacc_q [MaxCols];
  logic signed [ColAccW-1:0] col_new;
  logic signed [SumW-1:0]    run_q, run_new;
  logic signed [SumW-1:0]    best_q;
  logic                      have_best_q;
  logic [RowW-1:0]           bt_q, bb_q;
  logic [ColW-1:0]           bl_q, br_q;
  logic                      take;
  int                        best_int;

  assign re_o    = (state_q == StRun);
  assign raddr_o = AddrW'(AddrW'(b_q) * AddrW'(MaxCols) + AddrW'(r_q));
  assign issue_last = (r_q == col_last_i) && (b_q == row_last_i)
                   && (l_q == col_last_i) && (t_q == row_last_i);

  always_comb begin
    state_d = state_q;
    t_d = t_q;
    l_d = l_q;
    b_d = b_q;
    r_d = r_q;
    case (state_q)
      StIdle: begin
        if (go_i) begin
          state_d = StRun;
          t_d = '0;
          l_d = '0;
          b_d = '0;
          r_d = '0;
        end
      end
      StRun: begin
        if (r_q != col_last_i) begin
          r_d = r_q + 1'b1;
        end else if (b_q != row_last_i) begin
          b_d = b_q + 1'b1;
          r_d = l_q;
        end else if (l_q != col_last_i) begin
          l_d = l_q + 1'b1;
          b_d = t_q;
          r_d = l_q + 1'b1;
        end else if (t_q != row_last_i) begin
          t_d = t_q + 1'b1;
          l_d = '0;
          b_d = t_q + 1'b1;
          r_d = '0;
        end else begin
          state_d = StDrain;
        end
      end
      StDrain: state_d = StDone;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      p_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      p_valid_q <= (state_q == StRun);
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    l_q <= l_d;
    b_q <= b_d;
    r_q <= r_d;
    p_t_q <= t_q;
    p_l_q <= l_q;
    p_b_q <= b_q;
    p_r_q <= r_q;
    p_first_b_q <= (b_q == t_q);
    p_first_r_q <= (r_q == l_q);
  end

  // column sums over rows top..bottom, then the running row sum left..right
  assign col_new = p_first_b_q ? ColAccW'(rdata_i)
                               : colacc_q[p_r_q] + ColAccW'(rdata_i);
  assign run_new = p_first_r_q ? SumW'(col_new) : run_q + SumW'(col_new);
  assign take    = !have_best_q || (run_new > best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q <= 1'b0;
    end else if (go_i && state_q == StIdle) begin
      have_best_q <= 1'b0;
    end else if (p_valid_q) begin
      have_best_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_valid_q) begin
      colacc_q[p_r_q] <= col_new;
      run_q <= run_new;
      if (take) begin
        best_q <= run_new;
        bt_q <= p_t_q;
        bb_q <= p_b_q;
        bl_q <= p_l_q;
        br_q <= p_r_q;
      end
    end
  end

  assign done_o = (state_q == StDone);

  always_comb begin
    best_int = int'(best_q);
    if (best_int > SatMax) begin
      best_int = SatMax;
    end else if (best_int < SatMin) begin
      best_int = SatMin;
    end
    res_o.sum    = SumOutW'(best_int);
    res_o.top    = BoundW'(bt_q);
    res_o.bottom = BoundW'(bb_q);
    res_o.left   = BoundW'(bl_q);
    res_o.right  = BoundW'(br_q);
  end

  `include "max_sum_submatrix_defines.svh"

  `MSM_ASSERT(a_run_valid, clk_i, rst_ni, (state_q == StRun) |=> p_valid_q, "no issue follow-up")
  `MSM_ASSERT(a_drain_last, clk_i, rst_ni, (state_q == StRun && issue_last) |=> (state_q == StDrain), "bad drain")
  `MSM_ASSERT(a_done_best, clk_i, rst_ni, done_o |-> have_best_q, "done without a rectangle")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the max-sum submatrix block
// Loads matrices of many sizes and contents and checks each reported sum and
// set of bounds against typed values or an exhaustive search over every rectangle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import msm_pkg::*;

  // Indexes past the size registers; writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare3 = 2'd3;
  localparam int RandItems = 1100;

  typedef enum logic {OpCfg, OpElem} step_op_e;

  typedef struct {
    step_op_e            op;
    logic [CfgIdxW-1:0]  idx;
    int                  data;
    bit                  typed;
    msm_res_t            res;
  } step_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic                    busy_o;
  logic signed [ElemW-1:0] element_value_i = '0;
  logic                    done_o;
  logic signed [SumOutW-1:0] best_sum_o;
  logic [BoundW-1:0]       top_row_o, bottom_row_o, left_col_o, right_col_o;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx_i = '0;
  logic [CfgW-1:0]         cfg_data_i = '0;

  // Predictor state: raw size registers, loaded elements, load position.
  logic [CfgW-1:0]         rows_reg = 5'd16;
  logic [CfgW-1:0]         cols_reg = 5'd16;
  int                      matrix [MaxRowsDef*MaxColsDef];
  int                      load_pos = 0;

  msm_res_t                pending_q[$];
  step_row_t               plan_q[$];
  int                      mismatches = 0;
  bit                      no_idle = 1'b0;
  int                      sent = 0;

  always #4 clk_i = ~clk_i;

  max_sum_submatrix dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .element_value_i,
    .done_o, .best_sum_o, .top_row_o, .bottom_row_o, .left_col_o,
    .right_col_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  function automatic int eff_size(logic [CfgW-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Exhaustive search over all rectangles using 2-D prefix sums; strict
  // compare in (top, left, bottom, right) order keeps the first tie.
  function automatic msm_res_t best_rectangle(int rows, int cols);
    longint   pre [MaxRowsDef+1][MaxColsDef+1];
    longint   run, s, best;
    msm_res_t res;
    for (int i = 0; i <= rows; i++)
      for (int j = 0; j <= cols; j++) pre[i][j] = 0;
    for (int i = 0; i < rows; i++) begin
      run = 0;
      for (int j = 0; j < cols; j++) begin
        run += matrix[i*cols + j];
        pre[i+1][j+1] = pre[i][j+1] + run;
      end
    end
    res = '0;
    best = pre[1][1];
    for (int t = 0; t < rows; t++)
      for (int l = 0; l < cols; l++)
        for (int b = t; b < rows; b++)
          for (int r = l; r < cols; r++) begin
            s = pre[b+1][r+1] - pre[t][r+1] - pre[b+1][l] + pre[t][l];
            if (s > best) begin
              best = s;
              res.top = BoundW'(t); res.bottom = BoundW'(b);
              res.left = BoundW'(l); res.right = BoundW'(r);
            end
          end
    if (best > 64'sd8388607) best = 64'sd8388607;
    if (best < -64'sd8388608) best = -64'sd8388608;
    res.sum = best[SumOutW-1:0];
    return res;
  endfunction

  // Account one accepted element; returns 1 with the result when it closes
  // the matrix.
  function automatic bit absorb_element(int v, output msm_res_t res);
    int rows = eff_size(rows_reg, MaxRowsDef);
    int cols = eff_size(cols_reg, MaxColsDef);
    if (load_pos >= rows*cols) load_pos = 0;
    matrix[load_pos] = v;
    load_pos++;
    res = '0;
    if (load_pos < rows*cols) return 0;
    load_pos = 0;
    res = best_rectangle(rows, cols);
    return 1;
  endfunction

  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Wait for the block to drain: every result in and busy low.
  task automatic settle();
    while (pending_q.size() != 0) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Called at a falling edge; drops start_i, waits for the block to drain,
  // writes the register and returns at a falling edge with start_i low.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, int data);
    start_i <= 1'b0;
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data[CfgW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegRowCount) begin
      rows_reg = data[CfgW-1:0];
      load_pos = 0;
    end else if (idx == RegColCount) begin
      cols_reg = data[CfgW-1:0];
      load_pos = 0;
    end
    @(negedge clk_i);
  endtask

  task automatic send_element(int v, bit typed, msm_res_t typed_res);
    int       gap = pick_gap();
    msm_res_t res;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    element_value_i <= v[ElemW-1:0];
    // Hold the transaction until the block takes it.
    do @(posedge clk_i); while (busy_o);
    if (absorb_element(v, res)) pending_q.push_back(typed ? typed_res : res);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic plan(step_op_e op, logic [CfgIdxW-1:0] idx, int data,
                      bit typed = 0, int sum = 0, int t = 0, int b = 0,
                      int l = 0, int r = 0);
    step_row_t row;
    row.op = op; row.idx = idx; row.data = data; row.typed = typed;
    row.res.sum = sum[SumOutW-1:0];
    row.res.top = BoundW'(t); row.res.bottom = BoundW'(b);
    row.res.left = BoundW'(l); row.res.right = BoundW'(r);
    plan_q.push_back(row);
  endtask

  function automatic int pick_value(int style);
    case (style)
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 16) - 8;
      2: return -$urandom_range(1, 32768);
      default: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
    endcase
  endfunction

  // Result check: the receiver cannot stall, so sample every done cycle.
  always @(posedge clk_i) begin
    msm_res_t want;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result sum=%0d", best_sum_o);
      end else begin
        want = pending_q.pop_front();
        if (best_sum_o !== want.sum || top_row_o !== want.top ||
            bottom_row_o !== want.bottom || left_col_o !== want.left ||
            right_col_o !== want.right) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp sum=%0d t=%0d b=%0d l=%0d r=%0d, got sum=%0d t=%0d b=%0d l=%0d r=%0d",
                     want.sum, want.top, want.bottom, want.left, want.right,
                     best_sum_o, top_row_o, bottom_row_o, left_col_o, right_col_o);
        end
      end
    end
  end

  initial begin
    #(8 * 3_000_000);
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    int rows, cols, style, fill, n;
    msm_res_t none;
    none = '0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero sizes act as 1, extremes of a single element.
    plan(OpCfg, RegRowCount, 0);
    plan(OpCfg, RegColCount, 0);
    plan(OpElem, '0, -32768, 1, -32768);
    plan(OpElem, '0, 32767, 1, 32767);
    plan(OpElem, '0, 0, 1, 0);
    plan(OpCfg, RegSpare2, 5);
    plan(OpCfg, RegSpare3, 31);
    plan(OpElem, '0, -1, 1, -1);
    // All-negative 2x2: the true maximum is reported, not nothing.
    plan(OpCfg, RegRowCount, 2);
    plan(OpCfg, RegColCount, 2);
    plan(OpElem, '0, -5);
    plan(OpElem, '0, -3);
    plan(OpElem, '0, -7);
    plan(OpElem, '0, -9, 1, -3, 0, 0, 1, 1);
    // Ties: first rectangle in (top, left, bottom, right) order wins.
    plan(OpElem, '0, 1);
    plan(OpElem, '0, -1);
    plan(OpElem, '0, -1);
    plan(OpElem, '0, 1, 1, 1, 0, 0, 0, 0);
    // A register write abandons a partial load.
    plan(OpElem, '0, 100);
    plan(OpCfg, RegRowCount, 1);
    plan(OpElem, '0, 1);
    plan(OpElem, '0, 2, 1, 3, 0, 0, 0, 1);
    // Oversize register acts as the maximum: a 16-row single column.
    plan(OpCfg, RegRowCount, 31);
    plan(OpCfg, RegColCount, 1);

    foreach (plan_q[k]) begin
      if (plan_q[k].op == OpCfg) write_reg(plan_q[k].idx, plan_q[k].data);
      else send_element(plan_q[k].data, plan_q[k].typed, plan_q[k].res);
    end
    for (int k = 0; k < 16; k++) send_element(pick_value(0), 0, none);

    // Random phases: mostly small sizes, the extremes now and then.
    n = 0;
    while (sent < RandItems) begin
      case ($urandom_range(0, 9))
        0: begin rows = 0; cols = $urandom_range(0, 31); end
        1: begin rows = $urandom_range(17, 31); cols = $urandom_range(1, 3); end
        default: begin rows = $urandom_range(1, 5); cols = $urandom_range(1, 5); end
      endcase
      // Two full-size matrices filled with the extreme values.
      fill = 0;
      if (n < 2) begin rows = 16; cols = 16; fill = 1; end
      if ($urandom_range(0, 1) != 0) begin
        write_reg(RegRowCount, rows);
        write_reg(RegColCount, cols);
      end else begin
        write_reg(RegColCount, cols);
        write_reg(RegRowCount, rows);
      end
      if ($urandom_range(0, 7) == 0)
        write_reg(CfgIdxW'(RegSpare2 | $urandom_range(0, 1)), $urandom_range(0, 31));
      no_idle = ($urandom_range(0, 3) == 0);
      rows = eff_size(CfgW'(rows), MaxRowsDef);
      cols = eff_size(CfgW'(cols), MaxColsDef);
      for (int m = (fill != 0) ? 1 : $urandom_range(2, 6); m > 0; m--) begin
        style = $urandom_range(0, 3);
        for (int e = 0; e < rows*cols; e++) begin
          if (fill != 0) send_element((n == 0) ? 32767 : -32768, 0, none);
          else send_element(pick_value(style), 0, none);
        end
      end
      // Now and then leave a broken load for the next write to drop.
      if ($urandom_range(0, 4) == 0 && rows*cols > 1)
        for (int e = $urandom_range(1, rows*cols - 1); e > 0; e--)
          send_element(pick_value(0), 0, none);
      n++;
    end

    start_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+design
design/msm_pkg.sv
design/msm_store.sv
design/msm_search.sv
design/max_sum_submatrix.sv
tb/sv/tb.sv
